FILE: sv/mrb_pkg.sv
`timescale 1ns / 1ps
// Package with the widths and beat types of the memory request buffer.
package mrb_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH = 32;
  localparam int unsigned SIZE_WIDTH = 2;
  localparam int unsigned NUM_SLOTS  = 2;

  typedef struct packed {
    logic                  push;
    logic [DATA_WIDTH-1:0] data;
    logic [ADDR_WIDTH-1:0] addr;
    logic                  store;
    logic                  load;
    logic [SIZE_WIDTH-1:0] size;
    logic                  ack;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [ADDR_WIDTH-1:0] addr;
    logic                  store;
    logic                  load;
    logic [SIZE_WIDTH-1:0] size;
    logic                  full;
    logic                  empty;
  } res_t;

endpackage

FILE: sv/two_entry_memory_request_buffer_core.sv
`timescale 1ns / 1ps
// Top level of the two-slot memory request buffer between a cache and the memory bus.
//
// Each input beat carries one clock tick of the cache side: an optional
// request push (data, address, size, store and load marks) and the bus
// acknowledge level. Each input beat yields exactly one result beat with the
// request presented to memory (data, address, store, load, size) and the
// full and empty flags, all showing the buffer state after that tick.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// The input register captures the beat, then the slot logic updates the
// two slots and loads the result register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the
// input register fills; in_stall_o then rises and holds further beats.
// Reset clears both slots, the slot pointer, the load wait flag and the
// held data and address, and leaves both registers empty.
module two_entry_memory_request_buffer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           push_req_i,
  input  logic [mrb_pkg::DATA_WIDTH-1:0] req_data_i,
  input  logic [mrb_pkg::ADDR_WIDTH-1:0] req_addr_i,
  input  logic                           req_store_i,
  input  logic                           req_load_i,
  input  logic [mrb_pkg::SIZE_WIDTH-1:0] req_size_i,
  input  logic                           bus_ack_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mrb_pkg::DATA_WIDTH-1:0] out_data_o,
  output logic [mrb_pkg::ADDR_WIDTH-1:0] out_addr_o,
  output logic                           out_store_o,
  output logic                           out_load_o,
  output logic [mrb_pkg::SIZE_WIDTH-1:0] out_size_o,
  output logic                           is_full_o,
  output logic                           is_empty_o
);
  import mrb_pkg::*;

  req_t req_in;
  req_t req_s1;
  logic s1_valid;
  logic adv;
  res_t res_d;
  res_t res_q;

  assign req_in.push  = push_req_i;
  assign req_in.data  = req_data_i;
  assign req_in.addr  = req_addr_i;
  assign req_in.store = req_store_i;
  assign req_in.load  = req_load_i;
  assign req_in.size  = req_size_i;
  assign req_in.ack   = bus_ack_i;

  mrb_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req_in),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .req_o      (req_s1)
  );

  mrb_slots u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_valid && adv),
    .req_i  (req_s1),
    .res_o  (res_d)
  );

  mrb_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .res_i       (res_d),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign out_data_o  = res_q.data;
  assign out_addr_o  = res_q.addr;
  assign out_store_o = res_q.store;
  assign out_load_o  = res_q.load;
  assign out_size_o  = res_q.size;
  assign is_full_o   = res_q.full;
  assign is_empty_o  = res_q.empty;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("Buffer reported full and empty at once.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (!out_store_o && !out_load_o && out_size_o == '0))
    else $error("Request shown on the bus while the buffer is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("Input stalled while the result register can advance.");

endmodule

FILE: sv/mrb_in_reg.sv
`timescale 1ns / 1ps
// Input register stage that captures one request beat per cycle while in_stall_o is low.
module mrb_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mrb_pkg::req_t req_i,
  input  logic          adv_i,
  output logic          valid_o,
  output mrb_pkg::req_t req_o
);
  import mrb_pkg::*;

  logic valid_q;
  logic valid_d;
  req_t req_q;
  logic load_en;

  assign in_stall_o = valid_q && !adv_i;
  assign load_en    = in_valid_i && !in_stall_o;
  assign valid_d    = load_en ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

FILE: sv/mrb_slots.sv
`timescale 1ns / 1ps
// Slot storage, acknowledge and write handling, and next result computation.
module mrb_slots (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  mrb_pkg::req_t req_i,
  output mrb_pkg::res_t res_o
);
  import mrb_pkg::*;

  logic [DATA_WIDTH-1:0] data_q  [NUM_SLOTS];
  logic [ADDR_WIDTH-1:0] addr_q  [NUM_SLOTS];
  logic [SIZE_WIDTH-1:0] size_q  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  store_q;
  logic [NUM_SLOTS-1:0]  load_q;
  logic [NUM_SLOTS-1:0]  valid_q;
  logic                  cur_q;
  logic                  lw_q;
  logic [DATA_WIDTH-1:0] held_data_q;
  logic [ADDR_WIDTH-1:0] held_addr_q;

  logic [DATA_WIDTH-1:0] data_d  [NUM_SLOTS];
  logic [ADDR_WIDTH-1:0] addr_d  [NUM_SLOTS];
  logic [SIZE_WIDTH-1:0] size_d  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  store_d;
  logic [NUM_SLOTS-1:0]  load_d;
  logic [NUM_SLOTS-1:0]  valid_d;
  logic                  cur_d;
  logic                  lw_d;
  logic [DATA_WIDTH-1:0] held_data_d;
  logic [ADDR_WIDTH-1:0] held_addr_d;
  logic                  wr_en;
  logic                  wr_idx;

  always_comb begin
    valid_d = valid_q;
    cur_d   = cur_q;
    lw_d    = lw_q;
    if (valid_q[cur_q]) begin
      if (req_i.ack) begin
        if (store_q[cur_q]) begin
          valid_d[cur_q] = 1'b0;
          cur_d          = ~cur_q;
        end else begin
          lw_d = 1'b1;
        end
      end else if (lw_q) begin
        lw_d           = 1'b0;
        valid_d[cur_q] = 1'b0;
        cur_d          = ~cur_q;
      end
    end

    wr_en  = 1'b0;
    wr_idx = cur_q;
    if (req_i.push) begin
      if (valid_q == '0) begin
        wr_en  = 1'b1;
        wr_idx = cur_q;
      end else if (!valid_q[0]) begin
        wr_en  = 1'b1;
        wr_idx = 1'b0;
      end else if (!valid_q[1]) begin
        wr_en  = 1'b1;
        wr_idx = 1'b1;
      end
    end

    store_d = store_q;
    load_d  = load_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      data_d[i] = data_q[i];
      addr_d[i] = addr_q[i];
      size_d[i] = size_q[i];
    end
    if (wr_en) begin
      data_d[wr_idx]  = req_i.data;
      addr_d[wr_idx]  = req_i.addr;
      size_d[wr_idx]  = req_i.size;
      store_d[wr_idx] = req_i.store;
      load_d[wr_idx]  = req_i.load;
      valid_d[wr_idx] = req_i.store | req_i.load;
    end

    held_data_d = held_data_q;
    held_addr_d = held_addr_q;
    res_o.store = 1'b0;
    res_o.load  = 1'b0;
    res_o.size  = '0;
    if (valid_d[cur_d]) begin
      held_data_d = data_d[cur_d];
      held_addr_d = addr_d[cur_d];
      res_o.store = store_d[cur_d];
      res_o.load  = load_d[cur_d];
      res_o.size  = size_d[cur_d];
    end
    res_o.data  = held_data_d;
    res_o.addr  = held_addr_d;
    res_o.full  = valid_d[0] && valid_d[1];
    res_o.empty = !valid_d[0] && !valid_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= '0;
      load_q      <= '0;
      valid_q     <= '0;
      cur_q       <= 1'b0;
      lw_q        <= 1'b0;
      held_data_q <= '0;
      held_addr_q <= '0;
    end else if (step_i) begin
      store_q     <= store_d;
      load_q      <= load_d;
      valid_q     <= valid_d;
      cur_q       <= cur_d;
      lw_q        <= lw_d;
      held_data_q <= held_data_d;
      held_addr_q <= held_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      data_q[wr_idx] <= req_i.data;
      addr_q[wr_idx] <= req_i.addr;
      size_q[wr_idx] <= req_i.size;
    end
  end

endmodule

FILE: sv/mrb_out_reg.sv
`timescale 1ns / 1ps
// Result register that holds one result beat until the receiver takes it.
module mrb_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mrb_pkg::res_t res_i,
  output logic          adv_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mrb_pkg::res_t res_o
);
  import mrb_pkg::*;

  logic valid_q;
  res_t res_q;

  assign adv_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: verif/request_buffer_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the bus view of the memory request buffer and compares every result beat.
module request_buffer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           push_req_i,
  input  logic [mrb_pkg::DATA_WIDTH-1:0] req_data_i,
  input  logic [mrb_pkg::ADDR_WIDTH-1:0] req_addr_i,
  input  logic                           req_store_i,
  input  logic                           req_load_i,
  input  logic [mrb_pkg::SIZE_WIDTH-1:0] req_size_i,
  input  logic                           bus_ack_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [mrb_pkg::DATA_WIDTH-1:0] out_data_i,
  input  logic [mrb_pkg::ADDR_WIDTH-1:0] out_addr_i,
  input  logic                           out_store_i,
  input  logic                           out_load_i,
  input  logic [mrb_pkg::SIZE_WIDTH-1:0] out_size_i,
  input  logic                           is_full_i,
  input  logic                           is_empty_i,
  output int                             fail_count_o,
  output int                             expected_left_o,
  output int                             checked_o,
  output int                             store_retired_o,
  output int                             load_retired_o,
  output int                             dropped_o
);
  import mrb_pkg::*;

  logic [DATA_WIDTH-1:0] slot_data  [NUM_SLOTS];
  logic [ADDR_WIDTH-1:0] slot_addr  [NUM_SLOTS];
  logic [SIZE_WIDTH-1:0] slot_size  [NUM_SLOTS];
  logic                  slot_store [NUM_SLOTS];
  logic                  slot_load  [NUM_SLOTS];
  logic                  slot_valid [NUM_SLOTS];
  logic                  cur_slot;
  logic                  load_wait;
  logic [DATA_WIDTH-1:0] held_data;
  logic [ADDR_WIDTH-1:0] held_addr;

  res_t bus_view_q[$];
  res_t expected_view;
  res_t actual_view;
  req_t tick_beat;
  int   fail_count;
  int   checked;
  int   store_retired;
  int   load_retired;
  int   dropped;

  assign fail_count_o    = fail_count;
  assign checked_o       = checked;
  assign store_retired_o = store_retired;
  assign load_retired_o  = load_retired;
  assign dropped_o       = dropped;

  function automatic void retire_slot();
    slot_valid[cur_slot] = 1'b0;
    cur_slot = ~cur_slot;
  endfunction

  function automatic void fill_slot(input logic idx, input req_t r);
    slot_data[idx]  = r.data;
    slot_addr[idx]  = r.addr;
    slot_store[idx] = r.store;
    slot_load[idx]  = r.load;
    slot_size[idx]  = r.size;
    slot_valid[idx] = r.store | r.load;
  endfunction

  // One clock tick of the buffer: acknowledge first, then the write, which
  // sees the occupancy from the start of the tick.
  function automatic res_t step_buffer(input req_t r);
    res_t y;
    logic cur;
    logic v0;
    logic v1;
    cur = cur_slot;
    v0  = slot_valid[0];
    v1  = slot_valid[1];
    if (slot_valid[cur]) begin
      if (r.ack) begin
        if (slot_store[cur]) begin
          retire_slot();
          store_retired++;
        end else begin
          load_wait = 1'b1;
        end
      end else if (load_wait) begin
        load_wait = 1'b0;
        retire_slot();
        load_retired++;
      end
    end
    if (r.push) begin
      if (!v0 && !v1) begin
        fill_slot(cur, r);
      end else if (!v0) begin
        fill_slot(1'b0, r);
      end else if (!v1) begin
        fill_slot(1'b1, r);
      end else begin
        dropped++;
      end
    end
    cur = cur_slot;
    if (slot_valid[cur]) begin
      held_data = slot_data[cur];
      held_addr = slot_addr[cur];
      y.store   = slot_store[cur];
      y.load    = slot_load[cur];
      y.size    = slot_size[cur];
    end else begin
      y.store = 1'b0;
      y.load  = 1'b0;
      y.size  = '0;
    end
    y.data  = held_data;
    y.addr  = held_addr;
    y.full  = slot_valid[0] & slot_valid[1];
    y.empty = ~slot_valid[0] & ~slot_valid[1];
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_data[i]  = '0;
        slot_addr[i]  = '0;
        slot_size[i]  = '0;
        slot_store[i] = 1'b0;
        slot_load[i]  = 1'b0;
        slot_valid[i] = 1'b0;
      end
      cur_slot      = 1'b0;
      load_wait     = 1'b0;
      held_data     = '0;
      held_addr     = '0;
      fail_count    = 0;
      checked       = 0;
      store_retired = 0;
      load_retired  = 0;
      dropped       = 0;
      bus_view_q.delete();
      expected_left_o <= 0;
    end else begin
      // A result beat can never belong to an input beat of the same edge.
      if (out_valid_i && !out_stall_i) begin
        actual_view.data  = out_data_i;
        actual_view.addr  = out_addr_i;
        actual_view.store = out_store_i;
        actual_view.load  = out_load_i;
        actual_view.size  = out_size_i;
        actual_view.full  = is_full_i;
        actual_view.empty = is_empty_i;
        if (bus_view_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Unexpected result beat: data %h addr %h store %b load %b size %0d",
                     out_data_i, out_addr_i, out_store_i, out_load_i, out_size_i);
          end
        end else begin
          expected_view = bus_view_q.pop_front();
          if (actual_view.data !== expected_view.data ||
              actual_view.addr !== expected_view.addr ||
              actual_view.store !== expected_view.store ||
              actual_view.load !== expected_view.load ||
              actual_view.size !== expected_view.size ||
              actual_view.full !== expected_view.full ||
              actual_view.empty !== expected_view.empty) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch on result beat %0d:", checked);
              $display("  expected data %h addr %h store %b load %b size %0d full %b empty %b",
                       expected_view.data, expected_view.addr, expected_view.store,
                       expected_view.load, expected_view.size, expected_view.full,
                       expected_view.empty);
              $display("  actual   data %h addr %h store %b load %b size %0d full %b empty %b",
                       actual_view.data, actual_view.addr, actual_view.store,
                       actual_view.load, actual_view.size, actual_view.full,
                       actual_view.empty);
            end
          end
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        tick_beat.push  = push_req_i;
        tick_beat.data  = req_data_i;
        tick_beat.addr  = req_addr_i;
        tick_beat.store = req_store_i;
        tick_beat.load  = req_load_i;
        tick_beat.size  = req_size_i;
        tick_beat.ack   = bus_ack_i;
        bus_view_q.push_back(step_buffer(tick_beat));
      end
      expected_left_o <= bus_view_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the memory request buffer testbench: clock, reset, stimulus and verdict.
module testbench;
  import mrb_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef enum logic {
    RX_FREE,
    RX_RANDOM
  } rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  push_req = 1'b0;
  logic [DATA_WIDTH-1:0] req_data = '0;
  logic [ADDR_WIDTH-1:0] req_addr = '0;
  logic                  req_store = 1'b0;
  logic                  req_load = 1'b0;
  logic [SIZE_WIDTH-1:0] req_size = '0;
  logic                  bus_ack = 1'b0;
  logic                  out_stall = 1'b0;

  logic                  in_stall;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_data;
  logic [ADDR_WIDTH-1:0] out_addr;
  logic                  out_store;
  logic                  out_load;
  logic [SIZE_WIDTH-1:0] out_size;
  logic                  is_full;
  logic                  is_empty;

  int fail_count;
  int expected_left;
  int checked;
  int store_retired;
  int load_retired;
  int dropped;

  rx_mode_e rx_mode = RX_FREE;
  int       hold_token = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       beats_sent = 0;
  int       pushes_sent = 0;
  logic     ack_level = 1'b0;

  two_entry_memory_request_buffer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .push_req_i  (push_req),
    .req_data_i  (req_data),
    .req_addr_i  (req_addr),
    .req_store_i (req_store),
    .req_load_i  (req_load),
    .req_size_i  (req_size),
    .bus_ack_i   (bus_ack),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .out_addr_o  (out_addr),
    .out_store_o (out_store),
    .out_load_o  (out_load),
    .out_size_o  (out_size),
    .is_full_o   (is_full),
    .is_empty_o  (is_empty)
  );

  request_buffer_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .push_req_i      (push_req),
    .req_data_i      (req_data),
    .req_addr_i      (req_addr),
    .req_store_i     (req_store),
    .req_load_i      (req_load),
    .req_size_i      (req_size),
    .bus_ack_i       (bus_ack),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .out_addr_i      (out_addr),
    .out_store_i     (out_store),
    .out_load_i      (out_load),
    .out_size_i      (out_size),
    .is_full_i       (is_full),
    .is_empty_i      (is_empty),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left),
    .checked_o       (checked),
    .store_retired_o (store_retired),
    .load_retired_o  (load_retired),
    .dropped_o       (dropped)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      return $urandom_range(1, 3);
    end else if (k < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic req_t beat(input logic push, input logic [DATA_WIDTH-1:0] data,
                                input logic [ADDR_WIDTH-1:0] addr, input logic store,
                                input logic load, input logic [SIZE_WIDTH-1:0] size,
                                input logic ack);
    req_t r;
    r.push  = push;
    r.data  = data;
    r.addr  = addr;
    r.store = store;
    r.load  = load;
    r.size  = size;
    r.ack   = ack;
    return r;
  endfunction

  // Acknowledge is held in runs so that loads see both a high level and a falling edge.
  function automatic req_t random_beat();
    req_t r;
    int   k;
    k = $urandom_range(0, 99);
    r.push  = ($urandom_range(0, 99) < 55);
    r.data  = $urandom;
    r.addr  = $urandom;
    r.size  = SIZE_WIDTH'($urandom_range(0, 3));
    r.store = (k < 45) || (k >= 85 && k < 92);
    r.load  = (k >= 45 && k < 92);
    if ($urandom_range(0, 99) < 30) begin
      ack_level = ~ack_level;
    end
    r.ack = ack_level;
    return r;
  endfunction

  task automatic send_beat(input req_t r);
    in_valid  <= 1'b1;
    push_req  <= r.push;
    req_data  <= r.data;
    req_addr  <= r.addr;
    req_store <= r.store;
    req_load  <= r.load;
    req_size  <= r.size;
    bus_ack   <= r.ack;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats_sent++;
    if (r.push) begin
      pushes_sent++;
    end
  endtask

  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int n, input bit gaps);
    for (int i = 0; i < n; i++) begin
      send_beat(random_beat());
      if (gaps && $urandom_range(0, 3) == 0) begin
        idle_for(pick_gap());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rx_mode == RX_FREE) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed walk through the slot rules with both data extremes.
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b1));
    send_beat(beat(1'b1, '1, '1, 1'b0, 1'b0, 2'd3, 1'b0));
    send_beat(beat(1'b1, '0, '0, 1'b1, 1'b0, 2'd0, 1'b0));
    send_beat(beat(1'b1, '1, '1, 1'b0, 1'b1, 2'd3, 1'b0));
    send_beat(beat(1'b1, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b0, 2'd1, 1'b0));
    send_beat(beat(1'b1, 32'hdead_beef, 32'h0bad_f00d, 1'b1, 1'b0, 2'd2, 1'b1));
    send_beat(beat(1'b1, 32'haaaa_5555, 32'h5555_aaaa, 1'b1, 1'b1, 2'd2, 1'b1));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b1));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b1));
    send_beat(beat(1'b1, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b0, 1'b1, 2'd1, 1'b0));
    send_beat(beat(1'b1, 32'h8000_0001, 32'h7fff_fffe, 1'b1, 1'b0, 2'd3, 1'b1));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_beat(beat(1'b1, 32'hffff_0000, 32'h0000_ffff, 1'b1, 1'b0, 2'd0, 1'b1));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b1));
    send_beat(beat(1'b1, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b1, 2'd2, 1'b1));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b1));
    send_beat(beat(1'b1, '1, '0, 1'b0, 1'b0, 2'd1, 1'b1));
    send_beat(beat(1'b0, '0, '0, 1'b0, 1'b0, 2'd0, 1'b0));
    wait_drained();

    // Back to back with a free receiver, then random gaps on both sides.
    send_random(300, 1'b0);
    rx_mode <= RX_RANDOM;
    send_random(350, 1'b1);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_token <= hold_token + 1;
    send_random(150, 1'b0);
    wait_drained();
    send_random(250, 1'b1);

    hold_token <= hold_token + 1;
    send_random(100, 1'b0);
    rx_mode <= RX_FREE;
    send_random(230, 1'b1);

    wait_drained();
    repeat (12) @(posedge clk_i);

    $display("Sent %0d input beats with %0d pushes; checked %0d result beats.",
             beats_sent, pushes_sent, checked);
    $display("Predicted %0d store retirements, %0d load retirements, %0d drops on full.",
             store_retired, load_retired, dropped);
    if (fail_count == 0 && expected_left == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
